// ===== rtl/cdt_pkg.sv =====
// Shared types, constants and the melody note table of the countdown timer.
package cdt_pkg;

  localparam int unsigned SEC_W   = 13;
  localparam int unsigned MS_W    = 16;
  localparam int unsigned TONE_W  = 10;
  localparam int unsigned DUR_W   = 8;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned MIN_W   = 7;
  localparam int unsigned SECD_W  = 6;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 32;

  localparam logic [MS_W-1:0]  MS_MAX      = '1;
  localparam logic [MIN_W-1:0] MINUTES_MAX = 7'd99;

  // Reciprocal of sixty for 13-bit counts: floor(r * 8739 / 2^19) == r / 60
  localparam int unsigned      RECIP_SHIFT = 19;
  localparam logic [13:0]      RECIP_60    = 14'd8739;

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_COUNTING = 2'd1,
    MODE_PAUSED   = 2'd2,
    MODE_FINISHED = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_SHORT_PRESET = 2'd0,
    REG_LONG_PRESET  = 2'd1,
    REG_TICKS_PER_S  = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_idx_t;

  localparam logic [SEC_W-1:0] SHORT_PRESET_RST = 13'd10;
  localparam logic [SEC_W-1:0] LONG_PRESET_RST  = 13'd3600;
  localparam logic [MS_W-1:0]  TICKS_PER_S_RST  = 16'd1000;

  typedef struct packed {
    logic [TONE_W-1:0] freq;
    logic [DUR_W-1:0]  dur;
  } note_t;

  // Melody ROM; entries past the eighth are silent notes of zero length.
  function automatic note_t note_rom(input logic [IDX_W-1:0] idx);
    note_t n;
    unique case (idx)
      4'd0:    n = '{freq: 10'd262, dur: 8'd100};
      4'd1:    n = '{freq: 10'd330, dur: 8'd100};
      4'd2:    n = '{freq: 10'd392, dur: 8'd100};
      4'd3:    n = '{freq: 10'd523, dur: 8'd200};
      4'd4:    n = '{freq: 10'd392, dur: 8'd100};
      4'd5:    n = '{freq: 10'd330, dur: 8'd100};
      4'd6:    n = '{freq: 10'd262, dur: 8'd200};
      4'd7:    n = '{freq: 10'd0,   dur: 8'd100};
      default: n = '{freq: 10'd0,   dur: 8'd0};
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/cdt_if.sv =====
// Request channels of the countdown timer: polling passes in, status results out.
interface cdt_in_if;
  logic valid;
  logic ready;
  logic ms_tick;
  logic key_short;
  logic key_long;
  logic key_clear;

  modport source (output valid, ms_tick, key_short, key_long, key_clear, input ready);
  modport sink   (input valid, ms_tick, key_short, key_long, key_clear, output ready);
endinterface

interface cdt_out_if
  import cdt_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [SEC_W-1:0]  seconds_left;
  logic [MIN_W-1:0]  display_minutes;
  logic [SECD_W-1:0] display_seconds;
  logic [TONE_W-1:0] tone_hz;
  logic              note_start;

  modport source (output valid, mode, seconds_left, display_minutes, display_seconds,
                  tone_hz, note_start, input ready);
  modport sink   (input valid, mode, seconds_left, display_minutes, display_seconds,
                  tone_hz, note_start, output ready);
endinterface

// ===== rtl/countdown_timer_with_melody_alarm_top.sv =====
// Countdown timer with looping melody alarm: top level.
//
// Each request on in_ch is one polling pass (millisecond tick plus three keys) and
// yields exactly one status result on out_ch. A request lands in an input register,
// and when the result register is free or being taken, the timer state and the result
// register are updated from it in one step, so the block takes one request every cycle
// while results are not stalled. The one-step state update (mode, second counter,
// millisecond counters, note ROM lookup) sets that rate; the minutes and seconds
// fields are derived from the held count by a reciprocal multiply at the output.
// A stalled result holds the input register, which then holds in_ch.ready low.
// Presets and ticks per second are written through the APB port at 0x0, 0x4, 0x8.
module countdown_timer_with_melody_alarm_top
  import cdt_pkg::*;
#(
  parameter int unsigned NOTE_COUNT = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  cdt_in_if.sink            in_ch,
  cdt_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam logic [IDX_W-1:0] NOTE_LAST = IDX_W'(NOTE_COUNT);

  // Configuration registers
  logic [SEC_W-1:0] short_preset_r;
  logic [SEC_W-1:0] long_preset_r;
  logic [MS_W-1:0]  ticks_per_s_r;
  reg_idx_t         reg_sel;
  logic             cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_preset_r <= SHORT_PRESET_RST;
      long_preset_r  <= LONG_PRESET_RST;
      ticks_per_s_r  <= TICKS_PER_S_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_SHORT_PRESET: short_preset_r <= pwdata[SEC_W-1:0];
        REG_LONG_PRESET:  long_preset_r  <= pwdata[SEC_W-1:0];
        REG_TICKS_PER_S:  ticks_per_s_r  <= pwdata[MS_W-1:0];
        REG_UNUSED:       ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_SHORT_PRESET: prdata = DATA_W'(short_preset_r);
      REG_LONG_PRESET:  prdata = DATA_W'(long_preset_r);
      REG_TICKS_PER_S:  prdata = DATA_W'(ticks_per_s_r);
      REG_UNUSED:       prdata = '0;
    endcase
  end

  // Input register
  logic s1_valid_r;
  logic tick_r, key_short_r, key_long_r, key_clear_r;
  logic out_valid_r;
  logic advance;

  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      tick_r      <= in_ch.ms_tick;
      key_short_r <= in_ch.key_short;
      key_long_r  <= in_ch.key_long;
      key_clear_r <= in_ch.key_clear;
    end
  end

  // Timer state
  mode_t             mode_r, mode_nxt;
  logic [SEC_W-1:0]  remaining_r, remaining_nxt;
  logic [MS_W-1:0]   ms_sec_r, ms_sec_nxt;
  logic [MS_W-1:0]   ms_note_r, ms_note_nxt;
  logic [IDX_W-1:0]  note_idx_r, note_idx_nxt;
  logic [DUR_W-1:0]  note_len_r, note_len_nxt;
  logic [TONE_W-1:0] tone_r, tone_nxt;
  logic              started;
  note_t             note;

  assign note = note_rom(note_idx_r);

  always_comb begin
    mode_nxt      = mode_r;
    remaining_nxt = remaining_r;
    ms_sec_nxt    = ms_sec_r;
    ms_note_nxt   = ms_note_r;
    note_idx_nxt  = note_idx_r;
    note_len_nxt  = note_len_r;
    tone_nxt      = tone_r;
    started       = 1'b0;

    // saturating millisecond counters run in every mode
    if (tick_r) begin
      if (ms_sec_nxt != MS_MAX)  ms_sec_nxt  = ms_sec_nxt + 1'b1;
      if (ms_note_nxt != MS_MAX) ms_note_nxt = ms_note_nxt + 1'b1;
    end

    if (key_short_r || key_long_r) begin
      unique case (mode_r)
        MODE_IDLE: begin
          remaining_nxt = key_long_r ? long_preset_r : short_preset_r;
          mode_nxt      = MODE_COUNTING;
          ms_sec_nxt    = '0;
        end
        MODE_COUNTING: mode_nxt = MODE_PAUSED;
        MODE_PAUSED: begin
          mode_nxt   = MODE_COUNTING;
          ms_sec_nxt = '0;
        end
        MODE_FINISHED: begin
          mode_nxt      = MODE_IDLE;
          remaining_nxt = '0;
          tone_nxt      = '0;
        end
      endcase
    end

    // clear overrides a start key in the same pass
    if (key_clear_r) begin
      mode_nxt      = MODE_IDLE;
      remaining_nxt = '0;
      tone_nxt      = '0;
    end

    if (mode_nxt == MODE_COUNTING) begin
      if (ms_sec_nxt >= ticks_per_s_r) begin
        if (remaining_nxt != '0) begin
          remaining_nxt = remaining_nxt - 1'b1;
          ms_sec_nxt    = '0;
        end else begin
          mode_nxt     = MODE_FINISHED;
          note_idx_nxt = '0;
        end
      end
    end else if (mode_nxt == MODE_FINISHED) begin
      if (ms_note_nxt >= MS_W'(note_len_r)) begin
        if (note_idx_r < NOTE_LAST) begin
          tone_nxt     = note.freq;
          note_len_nxt = note.dur;
          ms_note_nxt  = '0;
          note_idx_nxt = note_idx_r + 1'b1;
          started      = 1'b1;
        end else begin
          // one idle pass at the wrap, tone held
          note_idx_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      remaining_r <= '0;
      ms_sec_r    <= '0;
      ms_note_r   <= MS_MAX;
      note_idx_r  <= '0;
      note_len_r  <= '0;
      tone_r      <= '0;
    end else if (advance) begin
      mode_r      <= mode_nxt;
      remaining_r <= remaining_nxt;
      ms_sec_r    <= ms_sec_nxt;
      ms_note_r   <= ms_note_nxt;
      note_idx_r  <= note_idx_nxt;
      note_len_r  <= note_len_nxt;
      tone_r      <= tone_nxt;
    end
  end

  // Result register
  logic started_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      started_r <= started;
    end
  end

  // Minutes and seconds from the held count
  logic [26:0]       div_prod;
  logic [7:0]        mins_full;
  logic [SEC_W-1:0]  mins_x60;
  logic [SEC_W-1:0]  secs_rem;

  assign div_prod  = {14'd0, remaining_r} * {13'd0, RECIP_60};
  assign mins_full = div_prod[RECIP_SHIFT+7:RECIP_SHIFT];
  assign mins_x60  = {mins_full[6:0], 6'd0} - {3'd0, mins_full, 2'd0};
  assign secs_rem  = remaining_r - mins_x60;

  assign out_ch.valid           = out_valid_r;
  assign out_ch.mode            = mode_r;
  assign out_ch.seconds_left    = remaining_r;
  assign out_ch.display_minutes = (mins_full > 8'(MINUTES_MAX)) ? MINUTES_MAX
                                                                : mins_full[MIN_W-1:0];
  assign out_ch.display_seconds = secs_rem[SECD_W-1:0];
  assign out_ch.tone_hz         = tone_r;
  assign out_ch.note_start      = started_r;

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the countdown timer: directed table, long tick runs, random phases.
`timescale 1ns / 1ps
module testbench;
  import cdt_pkg::*;

  localparam int TUNE_LEN    = 8;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int MELODY_SOAK = 210;
  localparam int PHASE_ITEMS = 100;

  // key order in a pass: tick, short start, long start, clear
  typedef struct packed {
    logic tick;
    logic k_short;
    logic k_long;
    logic k_clear;
  } pass_t;

  typedef struct packed {
    mode_t              mode;
    logic [SEC_W-1:0]   secs;
    logic [MIN_W-1:0]   mins;
    logic [SECD_W-1:0]  dsecs;
    logic [TONE_W-1:0]  tone;
    logic               note_start;
  } status_t;

  typedef enum bit {ROW_PASS, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    pass_t       keys;
    reg_idx_t    idx;
    logic [15:0] value;
    bit          known;
    status_t     want;
  } row_t;

  localparam pass_t TICK_ONLY   = 4'b1000;
  localparam pass_t START_SHORT = 4'b0100;
  localparam pass_t CLEAR_KEY   = 4'b0001;

  // melody: tone in Hz and length in ms ticks
  localparam logic [TONE_W-1:0] TUNE_HZ [TUNE_LEN] = '{262, 330, 392, 523, 392, 330, 262, 0};
  localparam logic [7:0]        TUNE_MS [TUNE_LEN] = '{100, 100, 100, 200, 100, 100, 200, 100};

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  cdt_in_if  in_ch ();
  cdt_out_if out_ch ();

  countdown_timer_with_melody_alarm_top #(.NOTE_COUNT(TUNE_LEN)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // predicted timer state and register copies
  mode_t             tmr_mode;
  logic [SEC_W-1:0]  count_left;
  logic [MS_W-1:0]   ms_in_second;
  logic [MS_W-1:0]   ms_in_note;
  logic [MS_W-1:0]   note_hold;
  logic [IDX_W-1:0]  note_pos;
  logic [TONE_W-1:0] tone_now;
  logic [SEC_W-1:0]  preset_short;
  logic [SEC_W-1:0]  preset_long;
  logic [MS_W-1:0]   tick_per_sec;

  status_t     pending_status [$];
  int          errors = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned cycle_cnt = 0;

  function automatic logic [MS_W-1:0] sat_up(logic [MS_W-1:0] v);
    return (v == MS_MAX) ? v : v + 1'b1;
  endfunction

  function automatic void stop_timer();
    tmr_mode   = MODE_IDLE;
    count_left = '0;
    tone_now   = '0;
  endfunction

  function automatic status_t advance_timer(pass_t p);
    status_t     r;
    int unsigned mins;
    r = '0;
    if (p.tick) begin
      ms_in_second = sat_up(ms_in_second);
      ms_in_note   = sat_up(ms_in_note);
    end
    if (p.k_short || p.k_long) begin
      case (tmr_mode)
        MODE_IDLE: begin
          count_left   = p.k_long ? preset_long : preset_short;
          tmr_mode     = MODE_COUNTING;
          ms_in_second = '0;
        end
        MODE_COUNTING: tmr_mode = MODE_PAUSED;
        MODE_PAUSED: begin
          tmr_mode     = MODE_COUNTING;
          ms_in_second = '0;
        end
        default: stop_timer();
      endcase
    end
    if (p.k_clear) stop_timer();

    if (tmr_mode == MODE_COUNTING) begin
      if (ms_in_second >= tick_per_sec) begin
        if (count_left != 0) begin
          count_left   = count_left - 1'b1;
          ms_in_second = '0;
        end else begin
          tmr_mode = MODE_FINISHED;
          note_pos = '0;
        end
      end
    end else if (tmr_mode == MODE_FINISHED && ms_in_note >= note_hold) begin
      if (note_pos < TUNE_LEN) begin
        tone_now     = TUNE_HZ[note_pos[2:0]];
        note_hold    = MS_W'(TUNE_MS[note_pos[2:0]]);
        ms_in_note   = '0;
        note_pos     = note_pos + 1'b1;
        r.note_start = 1'b1;
      end else begin
        note_pos = '0;
      end
    end

    mins = count_left / 60;
    if (mins > 99) mins = 99;
    r.mode  = tmr_mode;
    r.secs  = count_left;
    r.mins  = MIN_W'(mins);
    r.dsecs = SECD_W'(count_left % 60);
    r.tone  = tone_now;
    return r;
  endfunction

  // Pick the next pass from the predicted mode: mostly well-formed runs, some noise.
  function automatic pass_t next_pass();
    pass_t       p;
    int unsigned roll;
    int unsigned sel;
    bit          pick;
    roll = $urandom_range(0, 99);
    sel  = $urandom_range(0, 2);
    pick = $urandom_range(0, 1);
    p    = pass_t'(4'($urandom_range(0, 15)));
    case (tmr_mode)
      MODE_IDLE: begin
        if (roll < 70) begin
          p.k_short = (sel != 1);
          p.k_long  = (sel != 0);
          p.k_clear = 1'b0;
        end
      end
      MODE_COUNTING: begin
        if (roll < 86) p = {$urandom_range(0, 9) != 0, 3'b000};
        else if (roll < 93) p = {p.tick, pick, !pick, 1'b0};
      end
      MODE_PAUSED: begin
        if (roll < 55) p = {$urandom_range(0, 9) != 0, 3'b000};
        else if (roll < 85) p = {p.tick, pick, !pick, 1'b0};
      end
      default: begin
        if (roll < 92) p = {$urandom_range(0, 9) != 0, 3'b000};
      end
    endcase
    return p;
  endfunction

  function automatic row_t pass_row(pass_t keys);
    row_t r;
    r.kind  = ROW_PASS;
    r.keys  = keys;
    r.idx   = REG_UNUSED;
    r.value = '0;
    r.known = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  function automatic row_t known_row(pass_t keys, status_t want);
    row_t r;
    r       = pass_row(keys);
    r.known = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic row_t cfg_row(reg_idx_t idx, logic [15:0] value);
    row_t r;
    r       = pass_row('0);
    r.kind  = ROW_WRITE;
    r.idx   = idx;
    r.value = value;
    return r;
  endfunction

  task automatic send_pass(pass_t p, bit known, status_t want);
    status_t got;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.ms_tick   <= p.tick;
    in_ch.key_short <= p.k_short;
    in_ch.key_long  <= p.k_long;
    in_ch.key_clear <= p.k_clear;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    got = advance_timer(p);
    pending_status.push_back(known ? want : got);
  endtask

  // Drop valid and wait until every pending result is back.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] value);
    logic [DATA_W-1:0] data;
    // junk above the register width must be dropped
    data    = ($urandom << ((idx == REG_TICKS_PER_S) ? MS_W : SEC_W)) | DATA_W'(value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SHORT_PRESET: preset_short = data[SEC_W-1:0];
      REG_LONG_PRESET:  preset_long  = data[SEC_W-1:0];
      REG_TICKS_PER_S:  tick_per_sec = data[MS_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      errors++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    status_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_status.size() == 0) begin
        errors++;
        $error("result with no pending request");
      end else begin
        want = pending_status.pop_front();
        check_field("mode", 16'(want.mode), 16'(out_ch.mode));
        check_field("seconds_left", 16'(want.secs), 16'(out_ch.seconds_left));
        check_field("display_minutes", 16'(want.mins), 16'(out_ch.display_minutes));
        check_field("display_seconds", 16'(want.dsecs), 16'(out_ch.display_seconds));
        check_field("tone_hz", 16'(want.tone), 16'(out_ch.tone_hz));
        check_field("note_start", 16'(want.note_start), 16'(out_ch.note_start));
      end
    end
  end

  always @(posedge clk) out_ch.ready <= rst_n && ($urandom_range(0, 99) >= stall_pct);

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    row_t rows [$];
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.ms_tick   <= 1'b0;
    in_ch.key_short <= 1'b0;
    in_ch.key_long  <= 1'b0;
    in_ch.key_clear <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;

    tmr_mode     = MODE_IDLE;
    count_left   = '0;
    ms_in_second = '0;
    ms_in_note   = MS_MAX;
    note_hold    = '0;
    note_pos     = '0;
    tone_now     = '0;
    preset_short = SHORT_PRESET_RST;
    preset_long  = LONG_PRESET_RST;
    tick_per_sec = TICKS_PER_S_RST;

    // reset presets: short 10, long 3600, 1000 ticks per second
    rows.push_back(known_row(4'b0000, '{MODE_IDLE, 13'd0, 7'd0, 6'd0, 10'd0, 1'b0}));
    rows.push_back(known_row(4'b1000, '{MODE_IDLE, 13'd0, 7'd0, 6'd0, 10'd0, 1'b0}));
    rows.push_back(known_row(4'b0010, '{MODE_COUNTING, 13'd3600, 7'd60, 6'd0, 10'd0, 1'b0}));
    rows.push_back(known_row(4'b0100, '{MODE_PAUSED, 13'd3600, 7'd60, 6'd0, 10'd0, 1'b0}));
    rows.push_back(known_row(4'b1100, '{MODE_COUNTING, 13'd3600, 7'd60, 6'd0, 10'd0, 1'b0}));
    // clear beats a start key in the same pass
    rows.push_back(known_row(4'b0101, '{MODE_IDLE, 13'd0, 7'd0, 6'd0, 10'd0, 1'b0}));
    // both start keys: long preset wins
    rows.push_back(known_row(4'b0110, '{MODE_COUNTING, 13'd3600, 7'd60, 6'd0, 10'd0, 1'b0}));
    rows.push_back(known_row(4'b0001, '{MODE_IDLE, 13'd0, 7'd0, 6'd0, 10'd0, 1'b0}));
    rows.push_back(known_row(4'b0100, '{MODE_COUNTING, 13'd10, 7'd0, 6'd10, 10'd0, 1'b0}));
    rows.push_back(known_row(4'b1111, '{MODE_IDLE, 13'd0, 7'd0, 6'd0, 10'd0, 1'b0}));
    // zero ticks per second: a second passes every pass
    rows.push_back(cfg_row(REG_TICKS_PER_S, 16'd0));
    rows.push_back(cfg_row(REG_SHORT_PRESET, 16'd0));
    rows.push_back(pass_row(4'b0100));
    rows.push_back(pass_row(4'b0000));
    rows.push_back(pass_row(4'b1000));
    rows.push_back(pass_row(4'b0100));
    // preset beyond range saturates the minutes
    rows.push_back(cfg_row(REG_SHORT_PRESET, 16'd8191));
    rows.push_back(cfg_row(REG_LONG_PRESET, 16'd5999));
    rows.push_back(pass_row(4'b0100));
    rows.push_back(pass_row(4'b0001));
    rows.push_back(pass_row(4'b0010));
    rows.push_back(pass_row(4'b0001));
    rows.push_back(cfg_row(REG_TICKS_PER_S, 16'hFFFF));
    rows.push_back(pass_row(4'b0100));
    rows.push_back(pass_row(4'b1001));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_WRITE) begin
        settle();
        write_reg(rows[i].idx, rows[i].value);
      end else begin
        send_pass(rows[i].keys, rows[i].known, rows[i].want);
      end
    end

    // Finish at once and play the opening notes of the melody.
    settle();
    write_reg(REG_TICKS_PER_S, 16'd0);
    write_reg(REG_SHORT_PRESET, 16'd0);
    send_pass(START_SHORT, 1'b0, '0);
    repeat (MELODY_SOAK) send_pass(TICK_ONLY, 1'b0, '0);
    send_pass(CLEAR_KEY, 1'b0, '0);

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        0: begin
          write_reg(REG_SHORT_PRESET, 16'd3);
          write_reg(REG_LONG_PRESET, 16'd5);
          write_reg(REG_TICKS_PER_S, 16'd2);
        end
        1: begin
          write_reg(REG_SHORT_PRESET, 16'd0);
          write_reg(REG_LONG_PRESET, 16'd1);
          write_reg(REG_TICKS_PER_S, 16'd0);
        end
        2: begin
          write_reg(REG_SHORT_PRESET, 16'd1);
          write_reg(REG_LONG_PRESET, 16'd8191);
          write_reg(REG_TICKS_PER_S, 16'd1);
        end
        3: begin
          write_reg(REG_SHORT_PRESET, 16'd5999);
          write_reg(REG_LONG_PRESET, 16'd2);
          write_reg(REG_TICKS_PER_S, 16'd3);
        end
        4: begin
          write_reg(REG_SHORT_PRESET, 16'($urandom_range(0, 6)));
          write_reg(REG_LONG_PRESET, 16'($urandom_range(0, 6)));
          write_reg(REG_TICKS_PER_S, 16'($urandom_range(0, 4)));
        end
        default: begin
          write_reg(REG_SHORT_PRESET, 16'($urandom_range(0, 8191)));
          write_reg(REG_LONG_PRESET, 16'($urandom_range(0, 8191)));
          write_reg(REG_TICKS_PER_S, 16'hFFFF);
        end
      endcase
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 76; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 76; end
        default: begin idle_pct = 22; stall_pct = 22; end
      endcase
      repeat (PHASE_ITEMS) send_pass(next_pass(), 1'b0, '0);
    end

    settle();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
